// ===== design/es2c_pkg.sv =====
// ----------------------------------------------------------------------------
// es2c_pkg: shared types and constants for the spherical-to-Cartesian encoder
// Field widths, fixed-point turn constants, the register index codes and the
// CORDIC arctangent table (2^-24 degree units).
// ----------------------------------------------------------------------------
package es2c_pkg;

	localparam int CNT_W      = 32;   // raw encoder count
	localparam int ANG_W      = 25;   // angle, 2^-16 deg
	localparam int RAD_W      = 23;   // radius, 2^-8 mm
	localparam int POS_W      = 24;   // position, 2^-8 mm
	localparam int ALPHA_W    = 17;
	localparam int SCALE_W    = 24;
	localparam int CFG_W      = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 184;

	// serial multiplier: A full width, B consumed one digit per cycle
	localparam int MA_W      = 40;
	localparam int MB_W      = 32;
	localparam int MUL_DIGIT = 4;
	localparam int P_W       = MA_W + MB_W;

	localparam int COR_W            = 34;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int RS_W             = 26;

	// azimuth reduction
	localparam int MOD_W   = 50;
	localparam int MOD_TOP = 22;
	localparam int K_W     = $clog2(MOD_TOP + 1);

	localparam logic signed [ANG_W:0] HALF_A    = 26'sd11796480;
	localparam logic signed [ANG_W:0] QUARTER_A = 26'sd5898240;
	localparam logic signed [ANG_W:0] FULL_A    = 26'sd23592960;
	localparam logic signed [MOD_W-1:0] HALF_M  = 50'sd11796480;
	localparam logic signed [MOD_W-1:0] FULL_M  = 50'sd23592960;

	localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [31:0] POS_MAX = 32'sd8388607;
	localparam logic signed [31:0] POS_MIN = -32'sd8388608;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

	localparam logic [ALPHA_W-1:0]      ALPHA_RST = 17'd13107;
	localparam logic [SCALE_W-1:0]      APC_RST   = 24'd1474560;
	localparam logic [SCALE_W-1:0]      LPC_RST   = 24'd1677722;
	localparam logic signed [ANG_W-1:0] PMIN_RST  = 25'sd0;
	localparam logic signed [ANG_W-1:0] PMAX_RST  = 25'sd11796480;
	localparam logic [RAD_W-1:0]        RMIN_RST  = 23'd0;
	localparam logic [RAD_W-1:0]        RMAX_RST  = 23'd8388607;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA            = 3'd0,
		CFG_ANGLE_PER_COUNT  = 3'd1,
		CFG_LENGTH_PER_COUNT = 3'd2,
		CFG_POLAR_MIN        = 3'd3,
		CFG_POLAR_MAX        = 3'd4,
		CFG_REACH_MIN        = 3'd5,
		CFG_REACH_MAX        = 3'd6
	} cfg_idx_t;

	function automatic logic signed [COR_W-1:0] atan_deg24(input logic [4:0] i);
		logic signed [COR_W-1:0] r;
		case (i)
			5'd0:  r = 34'sd754974720;
			5'd1:  r = 34'sd445687602;
			5'd2:  r = 34'sd235489088;
			5'd3:  r = 34'sd119537938;
			5'd4:  r = 34'sd60000934;
			5'd5:  r = 34'sd30029717;
			5'd6:  r = 34'sd15018523;
			5'd7:  r = 34'sd7509720;
			5'd8:  r = 34'sd3754917;
			5'd9:  r = 34'sd1877466;
			5'd10: r = 34'sd938734;
			5'd11: r = 34'sd469367;
			5'd12: r = 34'sd234684;
			5'd13: r = 34'sd117342;
			5'd14: r = 34'sd58671;
			5'd15: r = 34'sd29335;
			5'd16: r = 34'sd14668;
			5'd17: r = 34'sd7334;
			5'd18: r = 34'sd3667;
			5'd19: r = 34'sd1833;
			5'd20: r = 34'sd917;
			5'd21: r = 34'sd458;
			5'd22: r = 34'sd229;
			5'd23: r = 34'sd115;
			default: r = '0;
		endcase
		return r;
	endfunction

	// bring an angle within +-16.7M into (-180, 180]; -180 maps to +180
	function automatic logic signed [ANG_W-1:0] wrap_half(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W:0] e;
		e = {a[ANG_W-1], a};
		if (e > HALF_A)
			e = e - FULL_A;
		else if (e <= -HALF_A)
			e = e + FULL_A;
		return e[ANG_W-1:0];
	endfunction

endpackage

// ===== design/es2c_mul.sv =====
// ----------------------------------------------------------------------------
// es2c_mul: digit-serial signed multiplier
// A is held whole, B is shifted out one MUL_DIGIT-bit digit per cycle (top
// digit signed); partial products enter a right-shifting accumulator.
// ----------------------------------------------------------------------------
module es2c_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [es2c_pkg::MA_W-1:0]    a,
	input  logic signed [es2c_pkg::MB_W-1:0]    b,
	output logic                                busy,
	output logic                                done,
	output logic signed [es2c_pkg::P_W-1:0]     p
);
	localparam int STEPS = es2c_pkg::MB_W / es2c_pkg::MUL_DIGIT;
	localparam int SC_W  = $clog2(STEPS);
	localparam int ACC_W = es2c_pkg::MA_W + es2c_pkg::MB_W + es2c_pkg::MUL_DIGIT + 1;
	localparam int DG    = es2c_pkg::MUL_DIGIT;

	logic signed [es2c_pkg::MA_W-1:0] a_q;
	logic [es2c_pkg::MB_W-1:0]        b_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic [SC_W-1:0]                  cnt_q;
	logic                             busy_q, done_q;

	logic                             dig_last;
	logic signed [DG:0]               dig;
	logic signed [es2c_pkg::MA_W+DG:0] part;
	logic signed [ACC_W-1:0]          sum;

	always_comb begin
		dig_last = (cnt_q == SC_W'(STEPS - 1));
		dig      = dig_last ? $signed({b_q[DG-1], b_q[DG-1:0]}) : $signed({1'b0, b_q[DG-1:0]});
		part     = a_q * dig;
		sum      = acc_q + (ACC_W'(part) <<< es2c_pkg::MB_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= sum >>> DG;
				b_q   <= b_q >> DG;
				if (dig_last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p    = $signed(acc_q[es2c_pkg::P_W-1:0]);

endmodule

// ===== design/es2c_cordic.sv =====
// ----------------------------------------------------------------------------
// es2c_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle
// Folds the angle into +-90 deg, rotates from the fixed gain, gives Q30
// sine and cosine with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module es2c_cordic #(
	parameter int STEPS = es2c_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [es2c_pkg::ANG_W-1:0]    angle,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [es2c_pkg::COR_W-1:0]    sin_out,
	output logic signed [es2c_pkg::COR_W-1:0]    cos_out
);
	localparam int IC_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CW   = es2c_pkg::COR_W;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [IC_W-1:0]      cnt_q;
	logic                 busy_q, done_q, neg_q;

	logic signed [es2c_pkg::ANG_W:0] a_ext, a_fold;
	logic                            neg0;
	logic signed [CW-1:0]            z0, x_sh, y_sh, at;

	always_comb begin
		a_ext  = {angle[es2c_pkg::ANG_W-1], angle};
		a_fold = a_ext;
		neg0   = 1'b0;
		if (a_ext > es2c_pkg::QUARTER_A) begin
			a_fold = es2c_pkg::HALF_A - a_ext;
			neg0   = 1'b1;
		end else if (a_ext < -es2c_pkg::QUARTER_A) begin
			a_fold = -es2c_pkg::HALF_A - a_ext;
			neg0   = 1'b1;
		end
		z0   = CW'(a_fold) <<< 8;
		x_sh = x_q >>> cnt_q;
		y_sh = y_q >>> cnt_q;
		at   = es2c_pkg::atan_deg24(5'(cnt_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= es2c_pkg::CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= z0;
				neg_q  <= neg0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + at;
				end
				if (cnt_q == IC_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign sin_out = y_q;
	assign cos_out = neg_q ? -x_q : x_q;

endmodule

// ===== design/encoder_spherical_to_cartesian_top.sv =====
// ----------------------------------------------------------------------------
// encoder_spherical_to_cartesian_top: encoder counts to smoothed x/y/z
// Converts azimuth, polar and wire counts to a clamped spherical position and
// an alpha-smoothed Cartesian position.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream s_*: one transfer per command. tuser selects the command:
//  0 computes a sample, 1 latches the three counts as zero offsets (no result;
//  the block stays idle). Output stream m_*: one transfer per sample.
//  Each of the ten products runs on one 4-bit-digit serial multiplier, the two
//  sine/cosine pairs on one CORDIC unit; the azimuth reduction and the output
//  load are steps of their own. One sample is in work at a time; the multiplier
//  sets the pace.
//  A finished result sits in the output register; the next command is taken
//  while it waits. If the receiver stalls, the following sample holds in its
//  last step until the output register frees.
//  Reset clears offsets, smoothing history and frame count and loads the
//  default register values. Write registers through cfg_* only while idle.
// ----------------------------------------------------------------------------
module encoder_spherical_to_cartesian_top #(
	parameter int CORDIC_STEPS = es2c_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// azimuth_count[31:0], polar_count[63:32], wire_count[95:64]
	input  logic [es2c_pkg::IN_DATA_W-1:0]        s_tdata,
	// func[0]
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pos_x[23:0], pos_y[47:24], pos_z[71:48], radius_out[94:72],
	// azimuth_out[119:95], polar_out[144:120], frame_number[176:145], zero fill
	output logic [es2c_pkg::OUT_DATA_W-1:0]       m_tdata,
	// valid_res[0]
	output logic                                  m_tuser,
	input  logic                                  cfg_we,
	input  logic [es2c_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [es2c_pkg::CFG_W-1:0]            cfg_data
);
	localparam int P_W   = es2c_pkg::P_W;
	localparam int ANG_W = es2c_pkg::ANG_W;
	localparam int COR_W = es2c_pkg::COR_W;
	localparam int RS_W  = es2c_pkg::RS_W;
	localparam int POS_W = es2c_pkg::POS_W;
	localparam int MOD_W = es2c_pkg::MOD_W;
	localparam int SM_W  = 48;

	localparam logic signed [P_W-1:0]  RND8  = P_W'(128);
	localparam logic signed [P_W-1:0]  RND16 = P_W'(32768);
	localparam logic signed [P_W-1:0]  RND30 = P_W'(536870912);
	localparam logic signed [SM_W-1:0] SRND  = SM_W'(32768);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL_AZ, ST_MOD, ST_FIX1, ST_FIX2, ST_MUL_POL, ST_MUL_RAD,
		ST_COR_POL, ST_COR_AZ, ST_MUL_RS, ST_MUL_X, ST_MUL_Y, ST_MUL_Z,
		ST_SM_X, ST_SM_Y, ST_SM_Z, ST_OUT
	} state_t;

	// configuration
	logic [es2c_pkg::ALPHA_W-1:0] alpha_q;
	logic [es2c_pkg::SCALE_W-1:0] apc_q, lpc_q;
	logic signed [ANG_W-1:0]      pmin_q, pmax_q;
	logic [es2c_pkg::RAD_W-1:0]   rmin_q, rmax_q;

	state_t                       state_q;
	logic                         phase_q;
	logic [31:0]                  azz_q, polz_q, wirez_q, frames_q;
	logic signed [31:0]           da_q, dp_q, dw_q;
	logic signed [MOD_W-1:0]      v_q;
	logic [es2c_pkg::K_W-1:0]     k_q;
	logic                         rawneg_q, sat_q;
	logic signed [ANG_W-1:0]      az_q, pol_q;
	logic [es2c_pkg::RAD_W-1:0]   rad_q;
	logic signed [COR_W-1:0]      sp_q, cpol_q, st_q, ct_q;
	logic signed [RS_W-1:0]       rs_q, xr_q, yr_q, zr_q;
	logic signed [POS_W-1:0]      last_x_q, last_y_q, last_z_q;
	logic                         m_tvalid_q, m_tuser_q;
	logic [es2c_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// shared units
	logic                          mul_start, mul_busy, mul_done;
	logic signed [es2c_pkg::MA_W-1:0] mul_a;
	logic signed [es2c_pkg::MB_W-1:0] mul_b;
	logic signed [P_W-1:0]         mul_p;
	logic                          cor_start, cor_busy, cor_done;
	logic signed [ANG_W-1:0]       cor_angle;
	logic signed [COR_W-1:0]       cor_sin, cor_cos;

	// datapath
	logic signed [P_W-1:0]   p_r8, p_r16, p_r30;
	logic signed [47:0]      v8, v16;
	logic signed [ANG_W-1:0] pol_cl;
	logic [es2c_pkg::RAD_W-1:0] rad_cl;
	logic signed [RS_W-1:0]  r30;
	logic signed [MOD_W-1:0] ft_sh, fix2_v;
	logic signed [RS_W-1:0]  sm_raw;
	logic signed [POS_W-1:0] sm_last, sm_res;
	logic signed [RS_W:0]    sm_diff;
	logic signed [SM_W-1:0]  sm_sum;
	logic signed [31:0]      sm_v, sm_sel;
	logic                    sm_sat, out_free, res_valid;
	logic [es2c_pkg::ALPHA_W-1:0] w;
	logic signed [es2c_pkg::MB_W-1:0] rad_b, w_b;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		w     = (alpha_q > es2c_pkg::ALPHA_ONE) ? es2c_pkg::ALPHA_ONE : alpha_q;
		rad_b = es2c_pkg::MB_W'($signed({1'b0, rad_q}));
		w_b   = es2c_pkg::MB_W'($signed({1'b0, w}));

		p_r8  = mul_p + RND8;
		p_r16 = mul_p + RND16;
		p_r30 = mul_p + RND30;
		v8    = p_r8[55:8];
		v16   = p_r16[63:16];
		r30   = p_r30[55:30];

		if (v8 < 48'(pmin_q))
			pol_cl = pmin_q;
		else if (v8 > 48'(pmax_q))
			pol_cl = pmax_q;
		else
			pol_cl = v8[ANG_W-1:0];

		if (v16 < $signed({25'b0, rmin_q}))
			rad_cl = rmin_q;
		else if (v16 > $signed({25'b0, rmax_q}))
			rad_cl = rmax_q;
		else
			rad_cl = v16[es2c_pkg::RAD_W-1:0];

		ft_sh  = es2c_pkg::FULL_M <<< k_q;
		fix2_v = v_q;
		if (v_q > es2c_pkg::HALF_M)
			fix2_v = v_q - es2c_pkg::FULL_M;
		if (fix2_v == es2c_pkg::HALF_M && rawneg_q)
			fix2_v = -es2c_pkg::HALF_M;

		cor_angle = es2c_pkg::wrap_half((state_q == ST_COR_POL) ? pol_q : az_q);

		sm_raw  = xr_q;
		sm_last = last_x_q;
		mul_a   = '0;
		mul_b   = '0;
		mul_start = 1'b0;
		cor_start = 1'b0;
		unique case (state_q) inside
			ST_SM_Y: begin
				sm_raw  = yr_q;
				sm_last = last_y_q;
			end
			ST_SM_Z: begin
				sm_raw  = zr_q;
				sm_last = last_z_q;
			end
			default: ;
		endcase
		sm_diff = (RS_W+1)'(sm_raw) - (RS_W+1)'(sm_last);

		unique case (state_q) inside
			ST_MUL_AZ:  begin mul_a = es2c_pkg::MA_W'(da_q); mul_b = 32'($signed({1'b0, apc_q})); end
			ST_MUL_POL: begin mul_a = es2c_pkg::MA_W'(dp_q); mul_b = 32'($signed({1'b0, apc_q})); end
			ST_MUL_RAD: begin mul_a = es2c_pkg::MA_W'(dw_q); mul_b = 32'($signed({1'b0, lpc_q})); end
			ST_MUL_RS:  begin mul_a = es2c_pkg::MA_W'(sp_q);   mul_b = rad_b; end
			ST_MUL_X:   begin mul_a = es2c_pkg::MA_W'(ct_q);   mul_b = 32'(rs_q); end
			ST_MUL_Y:   begin mul_a = es2c_pkg::MA_W'(st_q);   mul_b = 32'(rs_q); end
			ST_MUL_Z:   begin mul_a = es2c_pkg::MA_W'(cpol_q); mul_b = rad_b; end
			ST_SM_X, ST_SM_Y, ST_SM_Z: begin
				mul_a = es2c_pkg::MA_W'(sm_diff);
				mul_b = w_b;
			end
			default: ;
		endcase

		unique case (state_q) inside
			ST_MUL_AZ, ST_MUL_POL, ST_MUL_RAD, ST_MUL_RS, ST_MUL_X, ST_MUL_Y,
			ST_MUL_Z, ST_SM_X, ST_SM_Y, ST_SM_Z: mul_start = !phase_q;
			ST_COR_POL, ST_COR_AZ:               cor_start = !phase_q;
			default: ;
		endcase

		// new = last + alpha * (raw - last), rounded from 2^-16
		sm_sum = (SM_W'(sm_last) <<< 16) + SM_W'(mul_p) + SRND;
		sm_v   = sm_sum[47:16];
		sm_sel = (frames_q == '0) ? 32'(sm_raw) : sm_v;
		sm_sat = (sm_sel > es2c_pkg::POS_MAX) || (sm_sel < es2c_pkg::POS_MIN);
		if (sm_sel > es2c_pkg::POS_MAX)
			sm_res = es2c_pkg::POS_MAX[POS_W-1:0];
		else if (sm_sel < es2c_pkg::POS_MIN)
			sm_res = es2c_pkg::POS_MIN[POS_W-1:0];
		else
			sm_res = sm_sel[POS_W-1:0];

		res_valid = !sat_q && rad_q >= rmin_q && rad_q <= rmax_q &&
			pol_q >= pmin_q && pol_q <= pmax_q;
	end

	es2c_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (mul_p)
	);

	es2c_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_angle),
		.busy    (cor_busy),
		.done    (cor_done),
		.sin_out (cor_sin),
		.cos_out (cor_cos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= es2c_pkg::ALPHA_RST;
			apc_q   <= es2c_pkg::APC_RST;
			lpc_q   <= es2c_pkg::LPC_RST;
			pmin_q  <= es2c_pkg::PMIN_RST;
			pmax_q  <= es2c_pkg::PMAX_RST;
			rmin_q  <= es2c_pkg::RMIN_RST;
			rmax_q  <= es2c_pkg::RMAX_RST;
		end else if (cfg_we) begin
			unique case (es2c_pkg::cfg_idx_t'(cfg_index))
				es2c_pkg::CFG_ALPHA:            alpha_q <= cfg_data[es2c_pkg::ALPHA_W-1:0];
				es2c_pkg::CFG_ANGLE_PER_COUNT:  apc_q   <= cfg_data[es2c_pkg::SCALE_W-1:0];
				es2c_pkg::CFG_LENGTH_PER_COUNT: lpc_q   <= cfg_data[es2c_pkg::SCALE_W-1:0];
				es2c_pkg::CFG_POLAR_MIN:        pmin_q  <= cfg_data[ANG_W-1:0];
				es2c_pkg::CFG_POLAR_MAX:        pmax_q  <= cfg_data[ANG_W-1:0];
				es2c_pkg::CFG_REACH_MIN:        rmin_q  <= cfg_data[es2c_pkg::RAD_W-1:0];
				es2c_pkg::CFG_REACH_MAX:        rmax_q  <= cfg_data[es2c_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			azz_q      <= '0;
			polz_q     <= '0;
			wirez_q    <= '0;
			frames_q   <= '0;
			da_q       <= '0;
			dp_q       <= '0;
			dw_q       <= '0;
			v_q        <= '0;
			k_q        <= '0;
			rawneg_q   <= 1'b0;
			sat_q      <= 1'b0;
			az_q       <= '0;
			pol_q      <= '0;
			rad_q      <= '0;
			sp_q       <= '0;
			cpol_q     <= '0;
			st_q       <= '0;
			ct_q       <= '0;
			rs_q       <= '0;
			xr_q       <= '0;
			yr_q       <= '0;
			zr_q       <= '0;
			last_x_q   <= '0;
			last_y_q   <= '0;
			last_z_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// in ST_OUT the load below decides m_tvalid_q
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser) begin
							azz_q   <= s_tdata[31:0];
							polz_q  <= s_tdata[63:32];
							wirez_q <= s_tdata[95:64];
						end else begin
							da_q    <= s_tdata[31:0] - azz_q;
							dp_q    <= s_tdata[63:32] - polz_q;
							dw_q    <= s_tdata[95:64] - wirez_q;
							sat_q   <= 1'b0;
							phase_q <= 1'b0;
							state_q <= ST_MUL_AZ;
						end
					end
				end
				ST_MUL_AZ: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q  <= 1'b0;
						v_q      <= MOD_W'(v8);
						rawneg_q <= v8[47];
						k_q      <= es2c_pkg::K_W'(es2c_pkg::MOD_TOP);
						state_q  <= ST_MOD;
					end
				end
				ST_MOD: begin
					// signed restoring reduction by 360 deg, one shifted turn per cycle
					if (v_q >= ft_sh)
						v_q <= v_q - ft_sh;
					else if (v_q < 0)
						v_q <= v_q + ft_sh;
					if (k_q == '0)
						state_q <= ST_FIX1;
					else
						k_q <= k_q - 1'b1;
				end
				ST_FIX1: begin
					if (v_q < 0)
						v_q <= v_q + es2c_pkg::FULL_M;
					state_q <= ST_FIX2;
				end
				ST_FIX2: begin
					az_q    <= fix2_v[ANG_W-1:0];
					state_q <= ST_MUL_POL;
				end
				ST_MUL_POL: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q <= 1'b0;
						pol_q   <= pol_cl;
						state_q <= ST_MUL_RAD;
					end
				end
				ST_MUL_RAD: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q <= 1'b0;
						rad_q   <= rad_cl;
						state_q <= ST_COR_POL;
					end
				end
				ST_COR_POL: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (cor_done) begin
						phase_q <= 1'b0;
						sp_q    <= cor_sin;
						cpol_q  <= cor_cos;
						state_q <= ST_COR_AZ;
					end
				end
				ST_COR_AZ: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (cor_done) begin
						phase_q <= 1'b0;
						st_q    <= cor_sin;
						ct_q    <= cor_cos;
						state_q <= ST_MUL_RS;
					end
				end
				ST_MUL_RS: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q <= 1'b0;
						rs_q    <= r30;
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q <= 1'b0;
						xr_q    <= r30;
						state_q <= ST_MUL_Y;
					end
				end
				ST_MUL_Y: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q <= 1'b0;
						yr_q    <= r30;
						state_q <= ST_MUL_Z;
					end
				end
				ST_MUL_Z: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q <= 1'b0;
						zr_q    <= r30;
						state_q <= ST_SM_X;
					end
				end
				ST_SM_X: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q  <= 1'b0;
						last_x_q <= sm_res;
						sat_q    <= sat_q | sm_sat;
						state_q  <= ST_SM_Y;
					end
				end
				ST_SM_Y: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q  <= 1'b0;
						last_y_q <= sm_res;
						sat_q    <= sat_q | sm_sat;
						state_q  <= ST_SM_Z;
					end
				end
				ST_SM_Z: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (mul_done) begin
						phase_q  <= 1'b0;
						last_z_q <= sm_res;
						sat_q    <= sat_q | sm_sat;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold here until the output register frees
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_valid;
						m_tdata_q  <= {7'b0, frames_q, pol_q, az_q, rad_q,
							last_z_q, last_y_q, last_x_q};
						frames_q   <= frames_q + 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && cor_busy))
		else $error("multiplier and CORDIC busy together");

	a_accept_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!mul_busy && !cor_busy))
		else $error("command taken while a unit is still working");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX2) |-> (v_q >= 0 && v_q < es2c_pkg::FULL_M))
		else $error("azimuth reduction out of range");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("finished sample not loaded into output register");

endmodule

// ===== tb/tb_encoder_spherical_to_cartesian_top.sv =====
// ----------------------------------------------------------------------------
// tb_encoder_spherical_to_cartesian_top: self-checking bench for the encoder
// Drives zero and sample commands over the input stream, predicts each sample's
// position, spherical values, validity and frame count in fixed point, and
// checks every output transfer field by field across several register setups.
// ----------------------------------------------------------------------------
module tb_encoder_spherical_to_cartesian_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CORDIC_ROUNDS = 16;
	localparam int  LIMIT_CYCLES  = 3000000;
	localparam int  SETTLE_CYCLES = 400;
	localparam int  HOLD_CYCLES   = 3000;
	localparam int  RAND_ITEMS    = 200;
	localparam bit  CMD_SAMPLE    = 1'b0;
	localparam bit  CMD_ZERO      = 1'b1;
	localparam longint HALF_T     = 64'sd11796480;
	localparam longint FULL_T     = 64'sd23592960;
	localparam longint QUARTER_T  = 64'sd5898240;

	typedef struct packed {
		logic [6:0]  fill;
		logic [31:0] frame;
		logic [24:0] polar;
		logic [24:0] azimuth;
		logic [22:0] radius;
		logic [23:0] z;
		logic [23:0] y;
		logic [23:0] x;
	} position_t;

	typedef struct {
		position_t pos;
		bit        ok;
	} sample_t;

	typedef struct {
		bit          cmd;
		logic [31:0] az;
		logic [31:0] pol;
		logic [31:0] wire_cnt;
		bit          typed;
		sample_t     want;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [es2c_pkg::IN_DATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [es2c_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [es2c_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [es2c_pkg::CFG_W-1:0] cfg_data;

	encoder_spherical_to_cartesian_top #(.CORDIC_STEPS(CORDIC_ROUNDS)) uut (.*);

	// predictor state and register copy
	longint alpha_r, apc_r, lpc_r, pmin_r, pmax_r, rmin_r, rmax_r;
	logic [31:0] az_zero, pol_zero, wire_zero, frames;
	longint last_x, last_y, last_z;

	sample_t pending_samples[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	int hold_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL encoder_spherical_to_cartesian_top");
			$finish;
		end
	end

	function automatic longint round_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint wrap_turn(longint a);
		longint r;
		r = a % FULL_T;
		if (r < 0) r += FULL_T;
		if (r > HALF_T) r -= FULL_T;
		return r;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void sin_cos(input longint a, output longint s, output longint c);
		longint x, y, z, nx;
		bit flip;
		x = 64'sd652032874;
		y = 0;
		flip = 0;
		a = wrap_turn(a);
		if (a > QUARTER_T) begin
			a = HALF_T - a;
			flip = 1;
		end else if (a < -QUARTER_T) begin
			a = -HALF_T - a;
			flip = 1;
		end
		z = a * 256;
		for (int i = 0; i < CORDIC_ROUNDS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(es2c_pkg::atan_deg24(5'(i)));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(es2c_pkg::atan_deg24(5'(i)));
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint smooth(longint raw, longint last, longint w, ref bit sat);
		longint v;
		v = raw;
		if (frames != 0)
			v = round_shift(w * raw + (65536 - w) * last, 16);
		if (v > 8388607) begin
			sat = 1;
			return 8388607;
		end
		if (v < -8388608) begin
			sat = 1;
			return -8388608;
		end
		return v;
	endfunction

	// advance the predictor by one sample and return its expected output
	function automatic sample_t predict_sample(logic [31:0] ca, logic [31:0] cp,
		logic [31:0] cw);
		sample_t r;
		longint da, dp, dw, raw_az, az, pol, rad, sp, cpol, st, ct, rs, w;
		bit sat;
		sat = 0;
		da = longint'($signed(ca - az_zero));
		dp = longint'($signed(cp - pol_zero));
		dw = longint'($signed(cw - wire_zero));
		raw_az = round_shift(da * apc_r, 8);
		az = wrap_turn(raw_az);
		if (az == HALF_T && raw_az < 0) az = -HALF_T;
		pol = clip(round_shift(dp * apc_r, 8), pmin_r, pmax_r);
		rad = clip(round_shift(dw * lpc_r, 16), rmin_r, rmax_r);
		sin_cos(pol, sp, cpol);
		sin_cos(az, st, ct);
		rs = round_shift(rad * sp, 30);
		w = (alpha_r > 65536) ? 65536 : alpha_r;
		last_x = smooth(round_shift(rs * ct, 30), last_x, w, sat);
		last_y = smooth(round_shift(rs * st, 30), last_y, w, sat);
		last_z = smooth(round_shift(rad * cpol, 30), last_z, w, sat);
		r.ok = !sat && rad >= rmin_r && rad <= rmax_r && pol >= pmin_r && pol <= pmax_r;
		r.pos = '0;
		r.pos.x = last_x[23:0];
		r.pos.y = last_y[23:0];
		r.pos.z = last_z[23:0];
		r.pos.radius = rad[22:0];
		r.pos.azimuth = az[24:0];
		r.pos.polar = pol[24:0];
		r.pos.frame = frames;
		frames = frames + 1;
		return r;
	endfunction

	task automatic write_reg(es2c_pkg::cfg_idx_t idx, logic [es2c_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			es2c_pkg::CFG_ALPHA:            alpha_r = longint'(val[16:0]);
			es2c_pkg::CFG_ANGLE_PER_COUNT:  apc_r = longint'(val[23:0]);
			es2c_pkg::CFG_LENGTH_PER_COUNT: lpc_r = longint'(val[23:0]);
			es2c_pkg::CFG_POLAR_MIN:        pmin_r = longint'($signed(val[24:0]));
			es2c_pkg::CFG_POLAR_MAX:        pmax_r = longint'($signed(val[24:0]));
			es2c_pkg::CFG_REACH_MIN:        rmin_r = longint'(val[22:0]);
			es2c_pkg::CFG_REACH_MAX:        rmax_r = longint'(val[22:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one command; hold valid across back-to-back transfers
	task automatic send_cmd(bit cmd, logic [31:0] ca, logic [31:0] cp, logic [31:0] cw,
		bit typed, sample_t want);
		sample_t got;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {cw, cp, ca};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_ZERO) begin
			az_zero = ca;
			pol_zero = cp;
			wire_zero = cw;
		end else begin
			got = predict_sample(ca, cp, cw);
			pending_samples.push_back(typed ? want : got);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endtask

	// output side: check each transfer, then pick tready for the next edge
	initial begin
		sample_t want;
		position_t got;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_samples.size() == 0) begin
					errors++;
					$display("%0t unexpected transfer: got %h", $time, m_tdata);
				end else begin
					want = pending_samples.pop_front();
					check_field("pos_x", 32'(want.pos.x), 32'(got.x));
					check_field("pos_y", 32'(want.pos.y), 32'(got.y));
					check_field("pos_z", 32'(want.pos.z), 32'(got.z));
					check_field("radius_out", 32'(want.pos.radius), 32'(got.radius));
					check_field("azimuth_out", 32'(want.pos.azimuth), 32'(got.azimuth));
					check_field("polar_out", 32'(want.pos.polar), 32'(got.polar));
					check_field("frame_number", want.pos.frame, got.frame);
					check_field("fill", 32'(want.pos.fill), 32'(got.fill));
					check_field("valid_res", 32'(want.ok), 32'(m_tuser));
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [31:0] pick_count(logic [31:0] base);
		if ($urandom_range(0, 99) < 15)
			return $urandom;
		return base + 32'($urandom_range(0, 8191)) - 32'd4096;
	endfunction

	initial begin
		row_t rows[$];
		row_t r;
		sample_t none;
		logic [31:0] a, p, w;
		none = '{pos: '0, ok: 1'b0};
		s_tvalid = 1'b0;
		s_tuser = CMD_SAMPLE;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = es2c_pkg::CFG_ALPHA;
		cfg_data = '0;
		arst_n = 1'b0;
		alpha_r = 13107; apc_r = 1474560; lpc_r = 1677722;
		pmin_r = 0; pmax_r = 11796480; rmin_r = 0; rmax_r = 8388607;
		az_zero = '0; pol_zero = '0; wire_zero = '0; frames = '0;
		last_x = 0; last_y = 0; last_z = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero sample right after reset: everything zero, in bounds
		rows.push_back('{CMD_SAMPLE, 32'd0, 32'd0, 32'd0, 1'b1, '{pos: '0, ok: 1'b1}});
		// azimuth landing on +180 and -180
		rows.push_back('{CMD_SAMPLE, 32'd2048, 32'd1024, 32'd10000, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, -32'sd2048, 32'd1024, 32'd10000, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'd6144, 32'd512, 32'd50000, 1'b0, none});
		// polar above and below its bounds, radius below and above
		rows.push_back('{CMD_SAMPLE, 32'd300, 32'd5000, 32'd20000, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'd300, -32'sd100, -32'sd20000, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'd700, 32'd1024, 32'h7fffffff, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, none});
		// zero latch, then differences that wrap in 32 bits
		rows.push_back('{CMD_ZERO, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'h80000000, 32'h80000400, 32'h80010000, 1'b0, none});
		rows.push_back('{CMD_ZERO, 32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'h12345678, 32'hedcbab87, 32'h0f1f0f0f, 1'b0, none});
		rows.push_back('{CMD_ZERO, 32'h7fffffff, 32'h00000000, 32'hffffffff, 1'b0, none});
		rows.push_back('{CMD_SAMPLE, 32'h7ffffc00, 32'h00000400, 32'h00020000, 1'b0, none});
		foreach (rows[i]) begin
			r = rows[i];
			send_cmd(r.cmd, r.az, r.pol, r.wire_cnt, r.typed, r.want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			s_tvalid <= 1'b0;
			drain();
			case (phase)
				0: ;
				1: begin
					write_reg(es2c_pkg::CFG_ALPHA, 25'd0);
					write_reg(es2c_pkg::CFG_ANGLE_PER_COUNT, 25'd16777215);
					write_reg(es2c_pkg::CFG_LENGTH_PER_COUNT, 25'd16777215);
					write_reg(es2c_pkg::CFG_POLAR_MIN, 25'(-32'sd11796480));
					write_reg(es2c_pkg::CFG_POLAR_MAX, 25'd11796480);
					write_reg(es2c_pkg::CFG_REACH_MIN, 25'd0);
					write_reg(es2c_pkg::CFG_REACH_MAX, 25'd8388607);
				end
				2: begin
					// full weight on the new sample, inverted bounds
					write_reg(es2c_pkg::CFG_ALPHA, 25'd65536);
					write_reg(es2c_pkg::CFG_ANGLE_PER_COUNT, 25'd1474560);
					write_reg(es2c_pkg::CFG_LENGTH_PER_COUNT, 25'd1677722);
					write_reg(es2c_pkg::CFG_POLAR_MIN, 25'd1000000);
					write_reg(es2c_pkg::CFG_POLAR_MAX, 25'(-32'sd1000000));
					write_reg(es2c_pkg::CFG_REACH_MIN, 25'd500000);
					write_reg(es2c_pkg::CFG_REACH_MAX, 25'd1000);
				end
				default: begin
					write_reg(es2c_pkg::CFG_ALPHA, 25'($urandom_range(0, 65536)));
					write_reg(es2c_pkg::CFG_ANGLE_PER_COUNT, 25'($urandom_range(1, 3000000)));
					write_reg(es2c_pkg::CFG_LENGTH_PER_COUNT, 25'($urandom_range(1, 16777215)));
					write_reg(es2c_pkg::CFG_POLAR_MIN, 25'(-$urandom_range(0, 11796480)));
					write_reg(es2c_pkg::CFG_POLAR_MAX, 25'($urandom_range(0, 11796480)));
					write_reg(es2c_pkg::CFG_REACH_MIN, 25'($urandom_range(0, 200000)));
					write_reg(es2c_pkg::CFG_REACH_MAX, 25'($urandom_range(200000, 8388607)));
				end
			endcase
			send_idle_pct = (phase < 2) ? 24 : (phase == 2) ? 53 : 0;
			recv_idle_pct = (phase < 2) ? 53 : (phase == 2) ? 24 : 0;
			// stall the output long enough that the input backs up
			if (phase == 1)
				hold_cnt = HOLD_CYCLES;
			for (int n = 0; n < RAND_ITEMS; n++) begin
				a = pick_count(az_zero);
				p = pick_count(pol_zero);
				w = pick_count(wire_zero);
				if ($urandom_range(0, 99) < 8)
					send_cmd(CMD_ZERO, $urandom, $urandom, $urandom, 1'b0, none);
				else
					send_cmd(CMD_SAMPLE, a, p, w, 1'b0, none);
			end
		end
		s_tvalid <= 1'b0;
		drain();
		if (errors == 0)
			$display("PASS encoder_spherical_to_cartesian_top");
		else
			$display("FAIL encoder_spherical_to_cartesian_top");
		$finish;
	end

endmodule

// ===== encoder_spherical_to_cartesian_top.f =====
design/es2c_pkg.sv
design/es2c_mul.sv
design/es2c_cordic.sv
design/encoder_spherical_to_cartesian_top.sv
tb/tb_encoder_spherical_to_cartesian_top.sv
